@@ sv/rpdp_pkg.sv @@
// shared types, constants and helpers for the rotate, project and depth-plot block
`default_nettype none

package rpdp_pkg;

   // screen defaults
   localparam int SCREEN_WIDTH_DEF  = 160;
   localparam int SCREEN_HEIGHT_DEF = 44;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_PLOT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_SIN_A = 3'd0;
   localparam logic [2:0] CSR_COS_A = 3'd1;
   localparam logic [2:0] CSR_SIN_B = 3'd2;
   localparam logic [2:0] CSR_COS_B = 3'd3;
   localparam logic [2:0] CSR_SIN_C = 3'd4;
   localparam logic [2:0] CSR_COS_C = 3'd5;
   localparam logic [2:0] CSR_DIST  = 3'd6;
   localparam logic [2:0] CSR_SCALE = 3'd7;

   // csr reset values
   localparam logic signed [15:0] TRIG_ONE   = 16'sd16384;
   localparam logic signed [15:0] TRIG_ZERO  = 16'sd0;
   localparam logic [9:0]         DIST_RST   = 10'd120;
   localparam logic [7:0]         SCALE_RST  = 8'd40;

   // field widths
   localparam int TRIG_W  = 16;
   localparam int COORD_W = 8;
   localparam int ADDR_W  = 13;
   localparam int DEPTH_W = 16;
   localparam int GLYPH_W = 8;
   localparam int DIST_W  = 10;
   localparam int SCALE_W = 8;

   // datapath widths
   localparam int P1_W    = COORD_W + TRIG_W;     // coordinate times trig
   localparam int P2_W    = P1_W + 1;             // sum of two such products
   localparam int R_W     = P2_W + TRIG_W;        // Q28 partial terms
   localparam int U2_W    = P1_W + TRIG_W;
   localparam int XA_W    = R_W + 1;
   localparam int BIG_W   = R_W + TRIG_W;         // Q42 partial terms
   localparam int X42_W   = BIG_W + 1;
   localparam int Z_FRAC  = 28;
   localparam int ZS_W    = 42;                   // Q28 depth
   localparam int DEN_W   = ZS_W + 14;
   localparam int S2_W    = SCALE_W + 2;          // doubled scale, signed
   localparam int HALF_W  = 11;                    // screen half size, signed
   localparam int NUM_W   = 70;
   localparam int Q_W     = 16;
   localparam int OOZ_REM_W = ZS_W + 1;

   // divider sequencing
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = 4;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_SCALE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_CELL,
      ST_MEM_RD,
      ST_MEM_CHK,
      ST_CLEAR,
      ST_ZERO
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic scale;
      logic div_load;
      logic div_step;
      logic cell_calc;
      logic mem_rd;
      logic res_mem;
      logic res_clr;
      logic res_zero;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       addr_ok;
      logic       z_pos;
      logic       on_screen;
   } stat_type;

   // clamp a trig register to [-1, 1] in Q1.14
   function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      r = v;
      if (v > TRIG_ONE) begin
         r = TRIG_ONE;
      end else if (v < -TRIG_ONE) begin
         r = -TRIG_ONE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/rpdp_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module rpdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     wr_en,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/rpdp_cdiv.sv @@
// restoring divider for one screen coordinate, one quotient bit a cycle while step is asserted
`default_nettype none

module rpdp_cdiv #(
   parameter int NUM_W = 70,
   parameter int DEN_W = 56,
   parameter int Q_W   = 16
) (
   input  wire logic                    clock,
   input  wire logic                    load,
   input  wire logic                    step,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [DEN_W-1:0] den,
   output logic             [Q_W-1:0]   quot,
   output logic                         neg,
   output logic                         ovf
);

   localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

   logic [CW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  dsh_ff, dsh_in;
   logic [Q_W-1:0] quot_ff, quot_in;
   logic           neg_ff, neg_in;
   logic           ovf_ff, ovf_in;
   logic [NUM_W-1:0] mag;
   logic [CW-1:0]  den_ext;
   logic           ge;

   // magnitude of the numerator, truncation handled by the caller via the sign
   assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_ext = CW'($unsigned(den));
   assign ge      = rem_ff >= dsh_ff;

   // next values
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (load) begin
         rem_in  = CW'(mag);
         dsh_in  = den_ext << (Q_W - 1);
         quot_in = '0;
         neg_in  = num[NUM_W-1];
         ovf_in  = CW'(mag) >= (den_ext << Q_W);
      end else if (step) begin
         rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

   assign quot = quot_ff;
   assign neg  = neg_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

@@ sv/rpdp_datapath.sv @@
// datapath: csr bank, rotation multipliers, dividers, depth and glyph stores
`default_nettype none

module rpdp_datapath #(
   parameter int SCREEN_WIDTH  = rpdp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = rpdp_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rpdp_pkg::cmd_type                   cmd,
   output rpdp_pkg::stat_type                       stat,
   input  wire logic [1:0]                          req_op,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_y,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_z,
   input  wire logic [rpdp_pkg::GLYPH_W-1:0]        req_glyph,
   input  wire logic [rpdp_pkg::ADDR_W-1:0]         req_cell_address,
   input  wire logic                                csr_write,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [15:0]                         csr_data,
   output logic                                     rsp_written,
   output logic [rpdp_pkg::ADDR_W-1:0]              rsp_cell_out,
   output logic [rpdp_pkg::GLYPH_W-1:0]             rsp_glyph_out,
   output logic [rpdp_pkg::DEPTH_W-1:0]             rsp_depth_out
);

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam logic signed [rpdp_pkg::HALF_W-1:0] HALF_X =
      rpdp_pkg::HALF_W'(SCREEN_WIDTH / 2);
   localparam logic signed [rpdp_pkg::HALF_W-1:0] HALF_Y =
      rpdp_pkg::HALF_W'(SCREEN_HEIGHT / 2);

   // csr bank
   logic signed [15:0] sin_a_ff, sin_a_in, cos_a_ff, cos_a_in;
   logic signed [15:0] sin_b_ff, sin_b_in, cos_b_ff, cos_b_in;
   logic signed [15:0] sin_c_ff, sin_c_in, cos_c_ff, cos_c_in;
   logic [rpdp_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [rpdp_pkg::SCALE_W-1:0] scale_ff, scale_in;

   always_comb begin
      sin_a_in = sin_a_ff;
      cos_a_in = cos_a_ff;
      sin_b_in = sin_b_ff;
      cos_b_in = cos_b_ff;
      sin_c_in = sin_c_ff;
      cos_c_in = cos_c_ff;
      dist_in  = dist_ff;
      scale_in = scale_ff;
      if (csr_write) begin
         case (csr_index)
            rpdp_pkg::CSR_SIN_A: sin_a_in = csr_data;
            rpdp_pkg::CSR_COS_A: cos_a_in = csr_data;
            rpdp_pkg::CSR_SIN_B: sin_b_in = csr_data;
            rpdp_pkg::CSR_COS_B: cos_b_in = csr_data;
            rpdp_pkg::CSR_SIN_C: sin_c_in = csr_data;
            rpdp_pkg::CSR_COS_C: cos_c_in = csr_data;
            rpdp_pkg::CSR_DIST:  dist_in  = csr_data[rpdp_pkg::DIST_W-1:0];
            rpdp_pkg::CSR_SCALE: scale_in = csr_data[rpdp_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_a_ff <= rpdp_pkg::TRIG_ZERO;
         cos_a_ff <= rpdp_pkg::TRIG_ONE;
         sin_b_ff <= rpdp_pkg::TRIG_ZERO;
         cos_b_ff <= rpdp_pkg::TRIG_ONE;
         sin_c_ff <= rpdp_pkg::TRIG_ZERO;
         cos_c_ff <= rpdp_pkg::TRIG_ONE;
         dist_ff  <= rpdp_pkg::DIST_RST;
         scale_ff <= rpdp_pkg::SCALE_RST;
      end else begin
         sin_a_ff <= sin_a_in;
         cos_a_ff <= cos_a_in;
         sin_b_ff <= sin_b_in;
         cos_b_ff <= cos_b_in;
         sin_c_ff <= sin_c_in;
         cos_c_ff <= cos_c_in;
         dist_ff  <= dist_in;
         scale_ff <= scale_in;
      end
   end

   // clamped trig values
   logic signed [15:0] sa, ca, sb, cb, sc, cc;
   assign sa = rpdp_pkg::sat_trig(sin_a_ff);
   assign ca = rpdp_pkg::sat_trig(cos_a_ff);
   assign sb = rpdp_pkg::sat_trig(sin_b_ff);
   assign cb = rpdp_pkg::sat_trig(cos_b_ff);
   assign sc = rpdp_pkg::sat_trig(sin_c_ff);
   assign cc = rpdp_pkg::sat_trig(cos_c_ff);

   // input capture
   logic [1:0]                          op_ff;
   logic signed [rpdp_pkg::COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [rpdp_pkg::GLYPH_W-1:0]        glyph_ff;
   logic [rpdp_pkg::ADDR_W-1:0]         addr_ff;
   logic [AW-1:0]                       cell_ff, cell_in;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff    <= req_op;
         px_ff    <= req_point_x;
         py_ff    <= req_point_y;
         pz_ff    <= req_point_z;
         glyph_ff <= req_glyph;
         addr_ff  <= req_cell_address;
      end
   end

   // stage 1: coordinate times trig
   logic signed [rpdp_pkg::P1_W-1:0] jca_ff, jca_in, ksa_ff, ksa_in, kca_ff, kca_in;
   logic signed [rpdp_pkg::P1_W-1:0] jsa_ff, jsa_in, icb_ff, icb_in, isb_ff, isb_in;

   assign jca_in = py_ff * ca;
   assign ksa_in = pz_ff * sa;
   assign kca_in = pz_ff * ca;
   assign jsa_in = py_ff * sa;
   assign icb_in = px_ff * cb;
   assign isb_in = px_ff * sb;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         jca_ff <= jca_in;
         ksa_ff <= ksa_in;
         kca_ff <= kca_in;
         jsa_ff <= jsa_in;
         icb_ff <= icb_in;
         isb_ff <= isb_in;
      end
   end

   // stage 2: pair sums and second trig factor
   logic signed [rpdp_pkg::P2_W-1:0] p_sum, q_sum;
   logic signed [rpdp_pkg::R_W-1:0]  r_ff, r_in, scp_ff, scp_in, ccp_ff, ccp_in, cbq_ff, cbq_in;
   logic signed [rpdp_pkg::U2_W-1:0] ccu_ff, ccu_in, scu_ff, scu_in;
   logic signed [rpdp_pkg::P1_W-1:0] isb2_ff;

   assign p_sum  = rpdp_pkg::P2_W'(jca_ff) + rpdp_pkg::P2_W'(ksa_ff);
   assign q_sum  = rpdp_pkg::P2_W'(kca_ff) - rpdp_pkg::P2_W'(jsa_ff);
   assign r_in   = sb * q_sum;
   assign scp_in = sc * p_sum;
   assign ccp_in = cc * p_sum;
   assign cbq_in = cb * q_sum;
   assign ccu_in = cc * icb_ff;
   assign scu_in = sc * icb_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         r_ff    <= r_in;
         scp_ff  <= scp_in;
         ccp_ff  <= ccp_in;
         cbq_ff  <= cbq_in;
         ccu_ff  <= ccu_in;
         scu_ff  <= scu_in;
         isb2_ff <= isb_ff;
      end
   end

   // stage 3: Q42 cross terms, Q28 partial sums and depth
   logic signed [rpdp_pkg::BIG_W-1:0] ccr_ff, ccr_in, scr_ff, scr_in;
   logic signed [rpdp_pkg::XA_W-1:0]  xa_ff, xa_in, ya_ff, ya_in;
   logic signed [rpdp_pkg::ZS_W-1:0]  z28_ff, z28_in;

   assign ccr_in = cc * r_ff;
   assign scr_in = sc * r_ff;
   assign xa_in  = rpdp_pkg::XA_W'(scp_ff) + rpdp_pkg::XA_W'(ccu_ff);
   assign ya_in  = rpdp_pkg::XA_W'(ccp_ff) - rpdp_pkg::XA_W'(scu_ff);
   assign z28_in = rpdp_pkg::ZS_W'(cbq_ff)
                 + (rpdp_pkg::ZS_W'(isb2_ff) <<< 14)
                 + $signed({4'b0, dist_ff, 28'b0});

   always_ff @(posedge clock) begin
      if (cmd.mul3) begin
         ccr_ff <= ccr_in;
         scr_ff <= scr_in;
         xa_ff  <= xa_in;
         ya_ff  <= ya_in;
         z28_ff <= z28_in;
      end
   end

   // stage 4: rotated X and Y in Q42, denominator in Q42
   logic signed [rpdp_pkg::X42_W-1:0] x42_ff, x42_in, y42_ff, y42_in;
   logic signed [rpdp_pkg::DEN_W-1:0] den_ff, den_in;

   assign x42_in = (rpdp_pkg::X42_W'(xa_ff) <<< 14) - rpdp_pkg::X42_W'(ccr_ff);
   assign y42_in = (rpdp_pkg::X42_W'(ya_ff) <<< 14) + rpdp_pkg::X42_W'(scr_ff);
   assign den_in = rpdp_pkg::DEN_W'(z28_ff) <<< 14;

   always_ff @(posedge clock) begin
      if (cmd.mul4) begin
         x42_ff <= x42_in;
         y42_ff <= y42_in;
         den_ff <= den_in;
      end
   end

   // stage 5: projection numerators
   logic signed [rpdp_pkg::S2_W-1:0]               s2_s;
   logic signed [rpdp_pkg::S2_W+rpdp_pkg::X42_W-1:0] sx_prod, sy_prod;
   logic signed [rpdp_pkg::HALF_W+rpdp_pkg::DEN_W-1:0] hx_prod, hy_prod;
   logic signed [rpdp_pkg::NUM_W-1:0] numx_ff, numx_in, numy_ff, numy_in;

   assign s2_s    = $signed({1'b0, scale_ff, 1'b0});
   assign sx_prod = s2_s * x42_ff;
   assign sy_prod = s2_s * y42_ff;
   assign hx_prod = HALF_X * den_ff;
   assign hy_prod = HALF_Y * den_ff;
   assign numx_in = rpdp_pkg::NUM_W'(sx_prod) + rpdp_pkg::NUM_W'(hx_prod);
   assign numy_in = rpdp_pkg::NUM_W'(sy_prod) + rpdp_pkg::NUM_W'(hy_prod);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         numx_ff <= numx_in;
         numy_ff <= numy_in;
      end
   end

   // coordinate dividers
   logic [rpdp_pkg::Q_W-1:0] xq, yq;
   logic                     x_neg, x_ovf, y_neg, y_ovf;

   rpdp_cdiv #(
      .NUM_W (rpdp_pkg::NUM_W),
      .DEN_W (rpdp_pkg::DEN_W),
      .Q_W   (rpdp_pkg::Q_W)
   ) u_xdiv (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (numx_ff),
      .den   (den_ff),
      .quot  (xq),
      .neg   (x_neg),
      .ovf   (x_ovf)
   );

   rpdp_cdiv #(
      .NUM_W (rpdp_pkg::NUM_W),
      .DEN_W (rpdp_pkg::DEN_W),
      .Q_W   (rpdp_pkg::Q_W)
   ) u_ydiv (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (numy_ff),
      .den   (den_ff),
      .quot  (yq),
      .neg   (y_neg),
      .ovf   (y_ovf)
   );

   // reciprocal depth divider, 2^44 over z
   logic [rpdp_pkg::OOZ_REM_W-1:0] orem_ff, orem_in, orem2, zd;
   logic [rpdp_pkg::Q_W-1:0]       oq_ff, oq_in;
   logic                           osat_ff, osat_in;
   logic                           oge;
   logic [rpdp_pkg::DEPTH_W-1:0]   ooz;

   assign orem2 = {orem_ff[rpdp_pkg::OOZ_REM_W-2:0], 1'b0};
   assign zd    = rpdp_pkg::OOZ_REM_W'($unsigned(z28_ff));
   assign oge   = orem2 >= zd;

   always_comb begin
      orem_in = orem_ff;
      oq_in   = oq_ff;
      osat_in = osat_ff;
      if (cmd.div_load) begin
         orem_in = rpdp_pkg::OOZ_REM_W'(1) << rpdp_pkg::Z_FRAC;
         oq_in   = '0;
         osat_in = zd <= (rpdp_pkg::OOZ_REM_W'(1) << rpdp_pkg::Z_FRAC);
      end else if (cmd.div_step) begin
         orem_in = oge ? orem2 - zd : orem2;
         oq_in   = {oq_ff[rpdp_pkg::Q_W-2:0], oge};
      end
   end

   always_ff @(posedge clock) begin
      orem_ff <= orem_in;
      oq_ff   <= oq_in;
      osat_ff <= osat_in;
   end

   assign ooz = osat_ff ? '1 : oq_ff;

   // screen bounds and linear cell
   logic x_ok, y_ok;
   assign x_ok = !x_ovf && (x_neg ? (xq == '0) : (32'(xq) < 32'(SCREEN_WIDTH)));
   assign y_ok = !y_ovf && (y_neg ? (yq == '0) : (32'(yq) < 32'(SCREEN_HEIGHT)));

   always_comb begin
      cell_in = cell_ff;
      if (cmd.load_in) begin
         cell_in = AW'(req_cell_address);
      end else if (cmd.cell_calc) begin
         cell_in = AW'(xq) + AW'(yq) * AW'(SCREEN_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // depth and glyph stores
   logic [rpdp_pkg::DEPTH_W-1:0] rd_depth, wr_depth;
   logic [rpdp_pkg::GLYPH_W-1:0] rd_glyph;
   logic                         win, mem_wr;

   assign win      = (op_ff == rpdp_pkg::OP_PLOT) && (ooz > rd_depth);
   assign mem_wr   = cmd.res_clr || (cmd.res_mem && win);
   assign wr_depth = cmd.res_clr ? '0 : ooz;

   rpdp_ram #(
      .WIDTH (rpdp_pkg::DEPTH_W),
      .DEPTH (CELLS)
   ) u_depth_ram (
      .clock   (clock),
      .addr    (cell_ff),
      .wr_en   (mem_wr),
      .wr_data (wr_depth),
      .rd_en   (cmd.mem_rd),
      .rd_data (rd_depth)
   );

   rpdp_ram #(
      .WIDTH (rpdp_pkg::GLYPH_W),
      .DEPTH (CELLS)
   ) u_glyph_ram (
      .clock   (clock),
      .addr    (cell_ff),
      .wr_en   (mem_wr),
      .wr_data (glyph_ff),
      .rd_en   (cmd.mem_rd),
      .rd_data (rd_glyph)
   );

   // result register
   logic                         wr_ff, wr_in;
   logic [rpdp_pkg::ADDR_W-1:0]  rcell_ff, rcell_in;
   logic [rpdp_pkg::GLYPH_W-1:0] rglyph_ff, rglyph_in;
   logic [rpdp_pkg::DEPTH_W-1:0] rdepth_ff, rdepth_in;

   always_comb begin
      wr_in     = wr_ff;
      rcell_in  = rcell_ff;
      rglyph_in = rglyph_ff;
      rdepth_in = rdepth_ff;
      if (cmd.res_zero) begin
         wr_in     = 1'b0;
         rcell_in  = '0;
         rglyph_in = '0;
         rdepth_in = '0;
      end else if (cmd.res_clr) begin
         wr_in     = 1'b0;
         rcell_in  = rpdp_pkg::ADDR_W'(cell_ff);
         rglyph_in = glyph_ff;
         rdepth_in = '0;
      end else if (cmd.res_mem) begin
         wr_in     = win;
         rcell_in  = rpdp_pkg::ADDR_W'(cell_ff);
         rglyph_in = win ? glyph_ff : rd_glyph;
         rdepth_in = win ? ooz : rd_depth;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff     <= wr_in;
      rcell_ff  <= rcell_in;
      rglyph_ff <= rglyph_in;
      rdepth_ff <= rdepth_in;
   end

   assign rsp_written   = wr_ff;
   assign rsp_cell_out  = rcell_ff;
   assign rsp_glyph_out = rglyph_ff;
   assign rsp_depth_out = rdepth_ff;

   // status to the controller
   assign stat.op        = op_ff;
   assign stat.addr_ok   = 32'(addr_ff) < 32'(CELLS);
   assign stat.z_pos     = z28_ff > 0;
   assign stat.on_screen = x_ok && y_ok;

endmodule

`default_nettype wire

@@ sv/rpdp_ctrl.sv @@
// controller: sequences one item at a time through the datapath
`default_nettype none

module rpdp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rpdp_pkg::stat_type stat,
   output rpdp_pkg::cmd_type       cmd,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready
);

   rpdp_pkg::state_type state_ff, state_in;
   logic [rpdp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic res_any;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpdp_pkg::ST_IDLE: begin
            if (req_valid) state_in = rpdp_pkg::ST_DECODE;
         end
         rpdp_pkg::ST_DECODE: begin
            if (stat.op == rpdp_pkg::OP_PLOT) begin
               state_in = rpdp_pkg::ST_MUL1;
            end else if (stat.op == rpdp_pkg::OP_CLEAR && stat.addr_ok) begin
               state_in = rpdp_pkg::ST_CLEAR;
            end else if (stat.op == rpdp_pkg::OP_READ && stat.addr_ok) begin
               state_in = rpdp_pkg::ST_MEM_RD;
            end else begin
               state_in = rpdp_pkg::ST_ZERO;
            end
         end
         rpdp_pkg::ST_MUL1: state_in = rpdp_pkg::ST_MUL2;
         rpdp_pkg::ST_MUL2: state_in = rpdp_pkg::ST_MUL3;
         rpdp_pkg::ST_MUL3: state_in = rpdp_pkg::ST_MUL4;
         rpdp_pkg::ST_MUL4: begin
            state_in = stat.z_pos ? rpdp_pkg::ST_SCALE : rpdp_pkg::ST_ZERO;
         end
         rpdp_pkg::ST_SCALE:    state_in = rpdp_pkg::ST_DIV_LOAD;
         rpdp_pkg::ST_DIV_LOAD: state_in = rpdp_pkg::ST_DIV_RUN;
         rpdp_pkg::ST_DIV_RUN: begin
            if (cnt_ff == rpdp_pkg::DIV_CNT_W'(rpdp_pkg::DIV_STEPS - 1)) begin
               state_in = rpdp_pkg::ST_CELL;
            end
         end
         rpdp_pkg::ST_CELL: begin
            state_in = stat.on_screen ? rpdp_pkg::ST_MEM_RD : rpdp_pkg::ST_ZERO;
         end
         rpdp_pkg::ST_MEM_RD: state_in = rpdp_pkg::ST_MEM_CHK;
         rpdp_pkg::ST_MEM_CHK, rpdp_pkg::ST_CLEAR, rpdp_pkg::ST_ZERO: begin
            if (out_free) state_in = rpdp_pkg::ST_IDLE;
         end
         default: state_in = rpdp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rpdp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         rpdp_pkg::ST_MUL1:     cmd.mul1      = 1'b1;
         rpdp_pkg::ST_MUL2:     cmd.mul2      = 1'b1;
         rpdp_pkg::ST_MUL3:     cmd.mul3      = 1'b1;
         rpdp_pkg::ST_MUL4:     cmd.mul4      = 1'b1;
         rpdp_pkg::ST_SCALE:    cmd.scale     = 1'b1;
         rpdp_pkg::ST_DIV_LOAD: cmd.div_load  = 1'b1;
         rpdp_pkg::ST_DIV_RUN:  cmd.div_step  = 1'b1;
         rpdp_pkg::ST_CELL:     cmd.cell_calc = stat.on_screen;
         rpdp_pkg::ST_MEM_RD:   cmd.mem_rd    = 1'b1;
         rpdp_pkg::ST_MEM_CHK:  cmd.res_mem   = out_free;
         rpdp_pkg::ST_CLEAR:    cmd.res_clr   = out_free;
         rpdp_pkg::ST_ZERO:     cmd.res_zero  = out_free;
         default: ;
      endcase
   end

   // divider step count
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.div_load) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // result valid flag
   assign res_any = cmd.res_mem || cmd.res_clr || cmd.res_zero;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpdp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/rotate_project_depth_plot_top.sv @@
// top level: rotates a point, projects it and plots it under a depth test
// plots behind the camera or off screen, like ignored items, end early with a zero result
// throughput: one item at a time, with the length of a plot set by the 16-step dividers
// results wait in an output register, so the next item is taken while one is pending
// reset: synchronous, active high; clears control and csr bank, stores stay undefined
`default_nettype none

module rotate_project_depth_plot_top #(
   parameter int SCREEN_WIDTH  = rpdp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = rpdp_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_op,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_y,
   input  wire logic signed [rpdp_pkg::COORD_W-1:0] req_point_z,
   input  wire logic [rpdp_pkg::GLYPH_W-1:0]        req_glyph,
   input  wire logic [rpdp_pkg::ADDR_W-1:0]         req_cell_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_written,
   output logic [rpdp_pkg::ADDR_W-1:0]              rsp_cell_out,
   output logic [rpdp_pkg::GLYPH_W-1:0]             rsp_glyph_out,
   output logic [rpdp_pkg::DEPTH_W-1:0]             rsp_depth_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [15:0]                         csr_data
);

   rpdp_pkg::cmd_type  cmd;
   rpdp_pkg::stat_type stat;

   // csr writes always taken
   assign csr_ready = 1'b1;

   rpdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   rpdp_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_glyph        (req_glyph),
      .req_cell_address (req_cell_address),
      .csr_write        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_written      (rsp_written),
      .rsp_cell_out     (rsp_cell_out),
      .rsp_glyph_out    (rsp_glyph_out),
      .rsp_depth_out    (rsp_depth_out)
   );

endmodule

`default_nettype wire

@@ sv/rpdp_checker.sv @@
// port-level checks for the top level, bound in below
`default_nettype none

module rpdp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_written,
   input wire logic [12:0] rsp_cell_out,
   input wire logic [15:0] rsp_depth_out
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_out) && $stable(rsp_depth_out))
      else $error("stalled result changed");

   // one item in flight: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // a winning plot always stores a non-zero depth
   a_win_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> rsp_depth_out != 16'd0)
      else $error("written result with zero depth");

   // nothing pending after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rotate_project_depth_plot_top rpdp_checker u_rpdp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_written   (rsp_written),
   .rsp_cell_out  (rsp_cell_out),
   .rsp_depth_out (rsp_depth_out)
);

`default_nettype wire
